/* rtl/rap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rap_pkg
// Shared types and constants of the rectangle atlas placer.
// ============================================================================
package rap_pkg;

    localparam int MaxRects   = 256;
    localparam int ADDR_W     = $clog2(MaxRects);
    localparam int COUNT_W    = $clog2(MaxRects + 1);
    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int GAP_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    // Candidate corners can run past the sheet: x + w + gap.
    localparam int CAND_W     = 14;
    localparam int SUM_W      = 15;

    localparam logic [DIM_W-1:0] SHEET_LIMIT = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHEET_W = 2'd0,
        CFG_SHEET_H = 2'd1,
        CFG_GAP     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND_RD,
        S_CAND_LD,
        S_TEST,
        S_SCAN,
        S_NEXT,
        S_STORE
    } t_state;

    // One stored padded box.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_rect;

endpackage
`default_nettype wire

/* rtl/rect_atlas_placer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rect_atlas_placer
// Greedy allocator that places padded rectangles on a 2D atlas sheet.
// ============================================================================
// An item is taken when start is high while busy is low. A clear beat or a
// place beat on a full table answers in the very next cycle with one result
// beat; a place beat that searches keeps busy high for the whole search and
// then answers. Every result is shown for exactly one cycle with o_strobe high
// and cannot be held off, so the receiver must take it in that cycle. Each
// candidate corner goes through a read of the rectangle that spawns it, a
// step that forms it, an inside-sheet test, one read of the rectangle table
// per stored entry through its single read port and a step to the next
// candidate. A place tries up to 3N + 1 candidate corners, where N is the
// number of stored rectangles. The user must write the sheet and gap
// registers through the cfg port only while idle; the block itself does
// not enforce it.
// ============================================================================
module rect_atlas_placer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_action,
    input  wire logic [rap_pkg::POS_W-1:0]         i_item_width,
    input  wire logic [rap_pkg::POS_W-1:0]         i_item_height,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [rap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rap_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output logic [1:0]                             o_status,
    output logic [rap_pkg::POS_W-1:0]              o_pos_x,
    output logic [rap_pkg::POS_W-1:0]              o_pos_y
);

    // Rectangle table: one synchronous memory, one read and one write port.
    rap_pkg::t_rect mem [rap_pkg::MaxRects];
    rap_pkg::t_rect r_rd_data;

    rap_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [rap_pkg::DIM_W-1:0] r_sheet_w, r_sheet_h;
    logic [rap_pkg::GAP_W-1:0] r_gap;

    // Search state.
    logic [rap_pkg::COUNT_W-1:0] r_count, n_count;
    logic [rap_pkg::DIM_W-1:0]   r_cw, n_cw, r_ch, n_ch;
    logic [rap_pkg::CAND_W-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic [1:0]                  r_pass, n_pass;
    logic [rap_pkg::ADDR_W-1:0]  r_cidx, n_cidx;
    logic [rap_pkg::COUNT_W-1:0] r_ridx, n_ridx;
    logic                        r_origin, n_origin;

    // Result registers.
    logic                        r_strobe, n_strobe;
    logic [1:0]                  r_status, n_status;
    logic [rap_pkg::POS_W-1:0]   r_px, n_px, r_py, n_py;

    logic [rap_pkg::ADDR_W-1:0]  rd_addr;
    logic                        wr_en;
    logic [rap_pkg::DIM_W-1:0]   lim_w, lim_h;
    logic                        on_sheet, overlap;
    logic [rap_pkg::CAND_W-1:0]  base_x_far, base_y_far;

    assign busy     = (r_state != rap_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_pos_x  = r_px;
    assign o_pos_y  = r_py;

    // Sheet sizes above the limit act as the limit.
    assign lim_w = (r_sheet_w > rap_pkg::SHEET_LIMIT) ? rap_pkg::SHEET_LIMIT : r_sheet_w;
    assign lim_h = (r_sheet_h > rap_pkg::SHEET_LIMIT) ? rap_pkg::SHEET_LIMIT : r_sheet_h;

    assign on_sheet = ({1'b0, r_cx} + rap_pkg::SUM_W'(r_cw) <= rap_pkg::SUM_W'(lim_w)) &&
                      ({1'b0, r_cy} + rap_pkg::SUM_W'(r_ch) <= rap_pkg::SUM_W'(lim_h));

    // Strict overlap of the candidate with the entry just read; touching
    // edges do not count.
    assign overlap =
        (rap_pkg::SUM_W'(r_rd_data.x) < {1'b0, r_cx} + rap_pkg::SUM_W'(r_cw)) &&
        ({1'b0, r_cx} < rap_pkg::SUM_W'(r_rd_data.x) + rap_pkg::SUM_W'(r_rd_data.w)) &&
        (rap_pkg::SUM_W'(r_rd_data.y) < {1'b0, r_cy} + rap_pkg::SUM_W'(r_ch)) &&
        ({1'b0, r_cy} < rap_pkg::SUM_W'(r_rd_data.y) + rap_pkg::SUM_W'(r_rd_data.h));

    // Corners past the right and bottom edges of the base rectangle.
    assign base_x_far = rap_pkg::CAND_W'(r_rd_data.x) + rap_pkg::CAND_W'(r_rd_data.w)
                        + rap_pkg::CAND_W'(r_gap);
    assign base_y_far = rap_pkg::CAND_W'(r_rd_data.y) + rap_pkg::CAND_W'(r_rd_data.h)
                        + rap_pkg::CAND_W'(r_gap);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cw     = r_cw;
        n_ch     = r_ch;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_pass   = r_pass;
        n_cidx   = r_cidx;
        n_ridx   = r_ridx;
        n_origin = r_origin;
        n_strobe = 1'b0;
        n_status = r_status;
        n_px     = r_px;
        n_py     = r_py;
        rd_addr  = r_cidx;
        wr_en    = 1'b0;

        case (r_state)
            rap_pkg::S_IDLE: begin
                if (start) begin
                    if (!i_action) begin
                        n_count  = '0;
                        n_strobe = 1'b1;
                        n_status = rap_pkg::ST_CLEARED;
                        n_px     = '0;
                        n_py     = '0;
                    end else if (r_count == rap_pkg::COUNT_W'(rap_pkg::MaxRects)) begin
                        n_strobe = 1'b1;
                        n_status = rap_pkg::ST_FULL;
                        n_px     = '0;
                        n_py     = '0;
                    end else begin
                        // The origin is the first candidate.
                        n_cw     = rap_pkg::DIM_W'(i_item_width) + 1'b1;
                        n_ch     = rap_pkg::DIM_W'(i_item_height) + 1'b1;
                        n_cx     = '0;
                        n_cy     = '0;
                        n_origin = 1'b1;
                        n_pass   = '0;
                        n_cidx   = '0;
                        n_state  = rap_pkg::S_TEST;
                    end
                end
            end
            rap_pkg::S_CAND_RD: begin
                rd_addr = r_cidx;
                n_state = rap_pkg::S_CAND_LD;
            end
            rap_pkg::S_CAND_LD: begin
                n_cx    = (r_pass == 2'd1) ? rap_pkg::CAND_W'(r_rd_data.x) : base_x_far;
                n_cy    = (r_pass == 2'd0) ? rap_pkg::CAND_W'(r_rd_data.y) : base_y_far;
                n_state = rap_pkg::S_TEST;
            end
            rap_pkg::S_TEST: begin
                rd_addr = '0;
                if (!on_sheet) begin
                    n_state = rap_pkg::S_NEXT;
                end else if (r_count == '0) begin
                    n_state = rap_pkg::S_STORE;
                end else begin
                    n_ridx  = rap_pkg::COUNT_W'(1);
                    n_state = rap_pkg::S_SCAN;
                end
            end
            rap_pkg::S_SCAN: begin
                // Entry r_ridx - 1 is on the read data this cycle.
                rd_addr = r_ridx[rap_pkg::ADDR_W-1:0];
                if (overlap) begin
                    n_state = rap_pkg::S_NEXT;
                end else if (r_ridx == r_count) begin
                    n_state = rap_pkg::S_STORE;
                end else begin
                    n_ridx = r_ridx + 1'b1;
                end
            end
            rap_pkg::S_NEXT: begin
                if (r_origin) begin
                    n_origin = 1'b0;
                    n_pass   = '0;
                    n_cidx   = '0;
                    n_state  = (r_count == '0) ? rap_pkg::S_IDLE : rap_pkg::S_CAND_RD;
                end else if ({1'b0, r_cidx} + 1'b1 == r_count) begin
                    n_cidx  = '0;
                    n_pass  = r_pass + 1'b1;
                    n_state = (r_pass == 2'd2) ? rap_pkg::S_IDLE : rap_pkg::S_CAND_RD;
                end else begin
                    n_cidx  = r_cidx + 1'b1;
                    n_state = rap_pkg::S_CAND_RD;
                end
                if (n_state == rap_pkg::S_IDLE) begin
                    n_strobe = 1'b1;
                    n_status = rap_pkg::ST_NOFIT;
                    n_px     = '0;
                    n_py     = '0;
                end
            end
            rap_pkg::S_STORE: begin
                wr_en    = 1'b1;
                n_count  = r_count + 1'b1;
                n_strobe = 1'b1;
                n_status = rap_pkg::ST_PLACED;
                n_px     = r_cx[rap_pkg::POS_W-1:0];
                n_py     = r_cy[rap_pkg::POS_W-1:0];
                n_state  = rap_pkg::S_IDLE;
            end
            default: begin
                n_state = rap_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rap_pkg::S_IDLE;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_sheet_w <= 13'd128;
            r_sheet_h <= 13'd128;
            r_gap     <= 4'd1;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    rap_pkg::CFG_SHEET_W: r_sheet_w <= i_cfg_data;
                    rap_pkg::CFG_SHEET_H: r_sheet_h <= i_cfg_data;
                    rap_pkg::CFG_GAP:     r_gap     <= i_cfg_data[rap_pkg::GAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw     <= n_cw;
        r_ch     <= n_ch;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_pass   <= n_pass;
        r_cidx   <= n_cidx;
        r_ridx   <= n_ridx;
        r_origin <= n_origin;
        r_status <= n_status;
        r_px     <= n_px;
        r_py     <= n_py;
    end

    // Table write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[rap_pkg::ADDR_W-1:0]] <= '{x: r_cx[rap_pkg::POS_W-1:0],
                                                   y: r_cy[rap_pkg::POS_W-1:0],
                                                   w: r_cw, h: r_ch};
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the rectangle atlas placer. A shadow copy of the
// atlas works out the answer to every accepted beat and a monitor compares
// each result beat with the oldest pending answer, field by field.
// ============================================================================
module tb;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 12;
    // The watchdog limit lies well above the run time of the slowest legal
    // place beat with a nearly full table.
    localparam int WATCHDOG_LIMIT  = 1_000_000;
    // A clear answers in the cycle right after it is taken. This is ample
    // margin for any stray result beat at the end of the run.
    localparam int DRAIN_CYCLES    = 10;
    // The random part clears the atlas once this many boxes are stored. This
    // keeps every search short.
    localparam int SHADOW_CLEAR_AT = 20;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_BEATS     = 25;

    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_PLACE = 1'b1;

    // One expected result beat.
    typedef struct {
        rap_pkg::t_status          status;
        logic [rap_pkg::POS_W-1:0] x;
        logic [rap_pkg::POS_W-1:0] y;
    } answer_t;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           start         = 1'b0;
    logic                           busy;
    logic                           i_action      = ACT_CLEAR;
    logic [rap_pkg::POS_W-1:0]      i_item_width  = '0;
    logic [rap_pkg::POS_W-1:0]      i_item_height = '0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [rap_pkg::CFG_IDX_W-1:0]  i_cfg_index   = rap_pkg::CFG_SHEET_W;
    logic [rap_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           o_strobe;
    logic [1:0]                     o_status;
    logic [rap_pkg::POS_W-1:0]      o_pos_x;
    logic [rap_pkg::POS_W-1:0]      o_pos_y;

    // Shadow of the atlas. The registers start at their reset values.
    rap_pkg::t_rect            shadow_rects [rap_pkg::MaxRects];
    int                        shadow_count   = 0;
    logic [rap_pkg::DIM_W-1:0] shadow_sheet_w = 13'd128;
    logic [rap_pkg::DIM_W-1:0] shadow_sheet_h = 13'd128;
    logic [rap_pkg::GAP_W-1:0] shadow_gap     = 4'd1;

    answer_t answers_due[$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    // When this is set, the sender offers each beat with no idle cycles.
    bit      no_idle      = 1'b0;

    rect_atlas_placer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_item_width  (i_item_width),
        .i_item_height (i_item_height),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow atlas
    // ------------------------------------------------------------------------

    // Any sheet register above 4096 behaves as a 4096 pixel sheet.
    function automatic int sheet_extent(input logic [rap_pkg::DIM_W-1:0] reg_val);
        return (reg_val > rap_pkg::SHEET_LIMIT) ? int'(rap_pkg::SHEET_LIMIT) : int'(reg_val);
    endfunction

    // A candidate is usable when it lies fully on the sheet and strictly
    // overlaps no stored box. Boxes that only share an edge do not collide.
    // The arithmetic is done at full integer width, so a candidate past the
    // sheet edge fails the bounds test and never wraps.
    function automatic bit box_is_free(input int cx, input int cy, input int cw, input int ch);
        int i;
        int rx, ry, rw, rh;
        if (cx + cw > sheet_extent(shadow_sheet_w)) return 1'b0;
        if (cy + ch > sheet_extent(shadow_sheet_h)) return 1'b0;
        for (i = 0; i < shadow_count; i++) begin
            rx = int'(shadow_rects[i].x);
            ry = int'(shadow_rects[i].y);
            rw = int'(shadow_rects[i].w);
            rh = int'(shadow_rects[i].h);
            if (cx < rx + rw && rx < cx + cw && cy < ry + rh && ry < cy + ch) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the answer to one beat and updates the shadow atlas.
    // A place pads the item by one pixel and tries the origin first. It then
    // tries the spot right of every stored box, then the spot below every
    // stored box, then the diagonal spot, each time in insertion order. A
    // full table answers at once and stores nothing.
    function automatic answer_t atlas_answer(input logic act,
                                             input logic [rap_pkg::POS_W-1:0] iw,
                                             input logic [rap_pkg::POS_W-1:0] ih);
        answer_t ans;
        int      cw, ch, cx, cy, n, pass, i;
        bit      found;
        ans = '{status: rap_pkg::ST_NOFIT, x: '0, y: '0};
        if (act == ACT_CLEAR) begin
            shadow_count = 0;
            ans.status   = rap_pkg::ST_CLEARED;
            return ans;
        end
        if (shadow_count >= rap_pkg::MaxRects) begin
            ans.status = rap_pkg::ST_FULL;
            return ans;
        end
        cw    = int'(iw) + 1;
        ch    = int'(ih) + 1;
        cx    = 0;
        cy    = 0;
        n     = shadow_count;
        found = box_is_free(cx, cy, cw, ch);
        for (pass = 0; pass < 3 && !found; pass++) begin
            for (i = 0; i < n && !found; i++) begin
                cx = int'(shadow_rects[i].x);
                cy = int'(shadow_rects[i].y);
                // The first pass steps right, the second steps down and the
                // third steps both ways.
                if (pass != 1) cx += int'(shadow_rects[i].w) + int'(shadow_gap);
                if (pass != 0) cy += int'(shadow_rects[i].h) + int'(shadow_gap);
                found = box_is_free(cx, cy, cw, ch);
            end
        end
        if (found) begin
            shadow_rects[n] = '{x: rap_pkg::POS_W'(cx), y: rap_pkg::POS_W'(cy),
                                w: rap_pkg::DIM_W'(cw), h: rap_pkg::DIM_W'(ch)};
            shadow_count++;
            ans.status = rap_pkg::ST_PLACED;
            ans.x      = rap_pkg::POS_W'(cx);
            ans.y      = rap_pkg::POS_W'(cy);
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offers one beat after a random idle gap and waits until the block takes
    // it. The answer is predicted at the edge that takes the beat. Start stays
    // high when the task returns, so back-to-back beats never drop it.
    task automatic send_beat(input logic act, input logic [rap_pkg::POS_W-1:0] iw,
                             input logic [rap_pkg::POS_W-1:0] ih);
        int      idle;
        answer_t due;
        idle = no_idle ? 0 : int'($urandom_range(0, 7));
        if (idle != 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_item_width  <= iw;
        i_item_height <= ih;
        do @(posedge i_clk); while (busy !== 1'b0);
        due         = atlas_answer(act, iw, ih);
        answers_due = {answers_due, due};
    endtask

    // Stops offering beats and waits until every pending answer has come
    // back. Every beat yields exactly one result, so the block is idle then.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
    endtask

    // Writes all three registers on consecutive edges. This must only be
    // called while the block is idle.
    task automatic set_sheet(input logic [rap_pkg::DIM_W-1:0] w,
                             input logic [rap_pkg::DIM_W-1:0] h,
                             input logic [rap_pkg::GAP_W-1:0] g);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= rap_pkg::CFG_SHEET_W;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= rap_pkg::CFG_SHEET_H;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_index <= rap_pkg::CFG_GAP;
        i_cfg_data  <= rap_pkg::CFG_DATA_W'(g);
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        shadow_sheet_w  = w;
        shadow_sheet_h  = h;
        shadow_gap      = g;
    endtask

    // Item sizes for the random part are mostly small, so that many boxes fit
    // and the searches go deep. Now and then a size spans the full field.
    function automatic logic [rap_pkg::POS_W-1:0] random_extent();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 15) return rap_pkg::POS_W'($urandom_range(0, 15));
        if (pick < 18) return rap_pkg::POS_W'($urandom_range(0, 255));
        return rap_pkg::POS_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // This test runs on the reset sheet of 128 by 128 with a gap of 1.
    task automatic test_default_sheet();
        send_beat(ACT_CLEAR, 12'hFFF, 12'hFFF);   // the clear ignores both sizes
        send_beat(ACT_PLACE, 12'd0, 12'd0);       // lands on the origin
        send_beat(ACT_PLACE, 12'd0, 12'd0);       // lands right of the first box
        send_beat(ACT_PLACE, 12'hFFF, 12'hFFF);   // far too big for the sheet
        send_beat(ACT_PLACE, 12'd126, 12'd126);   // fits only where the origin is free
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        send_beat(ACT_PLACE, 12'd127, 12'd127);   // fills the whole sheet
        send_beat(ACT_PLACE, 12'd0, 12'd0);       // the origin is taken, every other candidate is off the sheet
    endtask

    // Boxes that share an edge must not count as overlapping.
    task automatic test_touching_edges();
        wait_drained();
        set_sheet(13'd64, 13'd64, 4'd0);
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        repeat (4) send_beat(ACT_PLACE, 12'd9, 12'd9);   // a row of boxes flush side by side
        send_beat(ACT_PLACE, 12'd63, 12'd9);             // spans the sheet under the row
        wait_drained();
        set_sheet(13'd64, 13'd64, 4'd15);
        send_beat(ACT_PLACE, 12'd9, 12'd9);
        send_beat(ACT_PLACE, 12'd4, 12'd4);
    endtask

    // This test covers a zero sheet, a one-pixel sheet, and sheet registers
    // at and above the 4096 cap.
    task automatic test_sheet_extremes();
        wait_drained();
        set_sheet(13'd0, 13'd4096, 4'd1);
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        send_beat(ACT_PLACE, 12'd0, 12'd0);       // nothing fits on a zero-width sheet
        wait_drained();
        set_sheet(13'd1, 13'd1, 4'd0);
        send_beat(ACT_PLACE, 12'd0, 12'd0);
        send_beat(ACT_PLACE, 12'd0, 12'd0);
        wait_drained();
        set_sheet(13'h1FFF, 13'h1FFF, 4'd15);     // both act as 4096
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        send_beat(ACT_PLACE, 12'hFFF, 12'hFFF);   // the padded box is exactly 4096
        send_beat(ACT_PLACE, 12'd0, 12'd0);
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        send_beat(ACT_PLACE, 12'hFFF, 12'd0);
        send_beat(ACT_PLACE, 12'd0, 12'hFFF);
        wait_drained();
        set_sheet(13'd4097, 13'd4096, 4'd0);
        send_beat(ACT_PLACE, 12'd0, 12'd4094);
    endtask

    // This test fills all MaxRects entries, then places on the full table and
    // clears it. On a one-pixel-wide sheet the boxes stack in a single column.
    // Every step to the right falls off the sheet, which keeps the searches
    // cheap while the table fills.
    task automatic test_table_full();
        wait_drained();
        set_sheet(13'd1, 13'd4096, 4'd0);
        no_idle = 1'b1;
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        repeat (rap_pkg::MaxRects) send_beat(ACT_PLACE, 12'd0, 12'd0);
        no_idle = 1'b0;
        send_beat(ACT_PLACE, 12'hFFF, 12'hFFF);   // rejected before any search
        send_beat(ACT_PLACE, 12'd0, 12'd0);
        send_beat(ACT_CLEAR, 12'd0, 12'd0);
        send_beat(ACT_PLACE, 12'd0, 12'd0);       // the table is usable again
    endtask

    // The random part runs in several phases, each with its own sheet and
    // gap. Most beats are places of small items. A clear comes now and then,
    // and always once the atlas holds SHADOW_CLEAR_AT boxes. One phase sends
    // its beats with no idle cycles.
    task automatic test_random_packing();
        int                        phase, k;
        logic                      act;
        logic [rap_pkg::POS_W-1:0] iw, ih;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    set_sheet(rap_pkg::DIM_W'($urandom_range(16, 256)),
                              rap_pkg::DIM_W'($urandom_range(16, 256)),
                              rap_pkg::GAP_W'($urandom_range(0, 15)));
                end
                1: begin
                    set_sheet(rap_pkg::DIM_W'($urandom_range(0, 8191)),
                              rap_pkg::DIM_W'($urandom_range(0, 8191)),
                              rap_pkg::GAP_W'($urandom_range(0, 15)));
                end
                2: begin
                    set_sheet(rap_pkg::DIM_W'($urandom_range(16, 64)),
                              rap_pkg::DIM_W'($urandom_range(16, 64)),
                              4'd0);
                end
                default: begin
                    set_sheet(13'd4096, 13'd4096, 4'd15);
                end
            endcase
            no_idle = (phase == 2);
            for (k = 0; k < PHASE_BEATS; k++) begin
                if (shadow_count >= SHADOW_CLEAR_AT) act = ACT_CLEAR;
                else act = ($urandom_range(0, 9) != 0) ? ACT_PLACE : ACT_CLEAR;
                iw = random_extent();
                ih = random_extent();
                send_beat(act, iw, ih);
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------

    // A result beat is valid for exactly one cycle and is taken at the edge
    // that ends that cycle. It is checked against the oldest pending answer.
    always @(posedge i_clk) begin : check_results
        answer_t due;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result beat: status %0d x %0d y %0d",
                       o_status, o_pos_x, o_pos_y);
                mismatches++;
            end else begin
                due = answers_due.pop_front();
                if (o_status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_status);
                    mismatches++;
                end
                if (o_pos_x !== due.x) begin
                    $error("pos_x: expected %0d, got %0d", due.x, o_pos_x);
                    mismatches++;
                end
                if (o_pos_y !== due.y) begin
                    $error("pos_y: expected %0d, got %0d", due.y, o_pos_y);
                    mismatches++;
                end
            end
        end
    end

    // The watchdog counts cycles in which no beat is taken and no result
    // appears. A hung block ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rect_atlas_placer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_sheet();
        test_touching_edges();
        test_sheet_extremes();
        test_table_full();
        test_random_packing();

        // Wait for the last answers, then give a stray result beat time to
        // show up.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("rect_atlas_placer: match");
        end else begin
            $display("rect_atlas_placer: mismatch");
        end
        $finish;
    end

endmodule
